@@ rtl/signed_int_to_decimal_ascii_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define SITDA_ASSERT_NOW(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("sitda: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define SITDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sitda: implication violated");

// The consequent holds in the cycle after the antecedent.
`define SITDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sitda: next-cycle implication violated");

`endif

@@ rtl/sitda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants of the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int DIGIT_BITS     = 4;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic clear;
		logic bit_shift;
		logic digit_shift;
	} cell_ctl_t;

endpackage

@@ rtl/sitda_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_cell
// One decimal digit of the conversion row. It doubles its digit with a bit
// from below (add three, then shift) or takes the digit of its lower neighbor.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_assert.svh"

module sitda_cell (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sitda_pkg::cell_ctl_t                  ctl,
	input  logic                                  bit_in,
	input  logic [sitda_pkg::DIGIT_BITS-1:0]      digit_in,
	output logic                                  bit_out,
	output logic [sitda_pkg::DIGIT_BITS-1:0]      digit
);

	logic [sitda_pkg::DIGIT_BITS-1:0] digit_q;
	logic [sitda_pkg::DIGIT_BITS-1:0] adj;

	always_comb begin
		if (digit_q >= 4'd5) begin
			adj = digit_q + 4'd3;
		end else begin
			adj = digit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.bit_shift) begin
			digit_q <= {adj[sitda_pkg::DIGIT_BITS-2:0], bit_in};
		end else if (ctl.digit_shift) begin
			digit_q <= digit_in;
		end
	end

	assign bit_out = adj[sitda_pkg::DIGIT_BITS-1];
	assign digit   = digit_q;

	`SITDA_ASSERT_NOW(digit_range_a, clk, arst_n, digit_q <= 4'd9)

endmodule

@@ rtl/signed_int_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer to its decimal text, one ASCII character per
// output item, with a minus sign first for negative values.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in       input      in_valid, in_stall   value
// out      output     out_valid, out_stall character, last
//
// An item is taken, its magnitude is shifted through the row of digit cells,
// leading zeros are dropped, and the text is sent: a minus sign first when
// negative, then the digits. The next item is taken once the last character
// of the text sits in the output register. Reset clears the control state and
// the digit cells. A stall on the output holds the character register and,
// while the sign or the digits are sent, the digit row.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_assert.svh"

module signed_int_to_decimal_ascii #(
	parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   character,
	output logic                         last
);

	localparam int NDIG   = (VALUE_BITS * 3 + 9) / 10;
	localparam int BCNT_W = $clog2(VALUE_BITS);
	localparam int DCNT_W = $clog2(NDIG + 1);
	localparam int DW     = sitda_pkg::DIGIT_BITS;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t                  st_q;
	logic [VALUE_BITS-1:0]   mag_q;
	logic                    neg_q;
	logic [BCNT_W-1:0]       bcnt_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic [7:0]              char_q;
	logic                    last_q;
	logic                    out_valid_q;

	logic                    in_acc;
	logic                    slot_free;
	logic                    load_out;
	logic                    top_zero;
	logic                    dcnt_one;
	logic [VALUE_BITS-1:0]   mag_in;
	sitda_pkg::cell_ctl_t    ctl;

	logic [DW-1:0]           dig [NDIG];
	logic                    carry [NDIG+1];

	assign in_stall  = (st_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign load_out  = slot_free && ((st_q == ST_SIGN) || (st_q == ST_EMIT));
	assign top_zero  = (dig[NDIG-1] == '0);
	assign dcnt_one  = (dcnt_q == DCNT_W'(1));
	assign mag_in    = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

	always_comb begin
		ctl.clear       = in_acc;
		ctl.bit_shift   = (st_q == ST_CONV);
		ctl.digit_shift = ((st_q == ST_SKIP) && top_zero && !dcnt_one)
		                  || ((st_q == ST_EMIT) && slot_free);
	end

	assign carry[0] = mag_q[VALUE_BITS-1];

	for (genvar i = 0; i < NDIG; i++) begin : g_cell
		logic [DW-1:0] from_below;
		if (i == 0) begin : g_first
			assign from_below = '0;
		end else begin : g_rest
			assign from_below = dig[i-1];
		end
		sitda_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.bit_in   (carry[i]),
			.digit_in (from_below),
			.bit_out  (carry[i+1]),
			.digit    (dig[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			bcnt_q <= '0;
			dcnt_q <= '0;
			neg_q  <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						neg_q  <= value[VALUE_BITS-1];
						bcnt_q <= '0;
						st_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcnt_q <= bcnt_q + 1'b1;
					if (bcnt_q == BCNT_W'(VALUE_BITS - 1)) begin
						dcnt_q <= DCNT_W'(NDIG);
						st_q   <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (top_zero && !dcnt_one) begin
						dcnt_q <= dcnt_q - 1'b1;
					end else if (neg_q) begin
						st_q <= ST_SIGN;
					end else begin
						st_q <= ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						dcnt_q <= dcnt_q - 1'b1;
						if (dcnt_one) begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mag_q <= mag_in;
		end else if (st_q == ST_CONV) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (st_q == ST_SIGN) begin
				char_q <= sitda_pkg::CHAR_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= sitda_pkg::CHAR_ZERO + {4'h0, dig[NDIG-1]};
				last_q <= dcnt_one;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	`SITDA_ASSERT_NEXT(conv_start_a, clk, arst_n, in_acc, (st_q == ST_CONV) && (bcnt_q == '0))
	`SITDA_ASSERT_NOW(dcnt_live_a, clk, arst_n, !((st_q == ST_SKIP) || (st_q == ST_SIGN) || (st_q == ST_EMIT)) || (dcnt_q != '0))
	`SITDA_ASSERT_IMP(minus_not_last_a, clk, arst_n, out_valid_q && (char_q == sitda_pkg::CHAR_MINUS), !last_q)
	`SITDA_ASSERT_NEXT(text_end_a, clk, arst_n, (st_q == ST_EMIT) && slot_free && dcnt_one, (st_q == ST_IDLE) && out_valid_q && last_q)

endmodule

@@ test/signed_int_to_decimal_ascii_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Sends signed 32-bit integers to the converter and checks every character it
// returns against the decimal text predicted here. Directed items cover the
// extremes and the digit-count boundaries. Random items follow in three
// phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;

	localparam int VALUE_BITS    = 32;
	localparam int SETTLE_CYCLES = 60;
	localparam int STUCK_LIMIT   = 4000;

	typedef struct {
		logic [7:0] code;
		logic       is_last;
	} text_char_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic signed [VALUE_BITS-1:0] value;
	logic                         out_valid;
	logic                         out_stall;
	logic [7:0]                   character;
	logic                         last;

	text_char_t expected_text[$];
	int         errors;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         stuck_cycles;

	signed_int_to_decimal_ascii #(
		.VALUE_BITS(VALUE_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.character(character),
		.last     (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void predict_decimal_text(input logic signed [VALUE_BITS-1:0] v);
		logic [VALUE_BITS-1:0] magnitude;
		logic [7:0]            digits[$];
		text_char_t            tc;
		magnitude = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
		do begin
			digits.push_front(sitda_pkg::CHAR_ZERO + 8'(magnitude % 10));
			magnitude = magnitude / 10;
		end while (magnitude != 0);
		if (v[VALUE_BITS-1]) begin
			tc.code    = sitda_pkg::CHAR_MINUS;
			tc.is_last = 1'b0;
			expected_text.push_back(tc);
		end
		foreach (digits[i]) begin
			tc.code    = digits[i];
			tc.is_last = (i == digits.size() - 1);
			expected_text.push_back(tc);
		end
	endfunction

	task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_stall);
		predict_decimal_text(v);
	endtask

	task automatic test_extremes();
		send_value(32'sd0);
		send_value(32'sd1);
		send_value(-32'sd1);
		send_value(32'sh7FFFFFFF);
		send_value(32'sh80000000);
		send_value(32'sh80000001);
		send_value(32'sh7FFFFFFE);
		send_value(32'sh55555555);
		send_value(32'shAAAAAAAA);
	endtask

	task automatic test_digit_boundaries();
		send_value(32'sd9);
		send_value(32'sd10);
		send_value(-32'sd9);
		send_value(-32'sd10);
		send_value(32'sd99);
		send_value(32'sd100);
		send_value(-32'sd100);
		send_value(32'sd999999999);
		send_value(32'sd1000000000);
		send_value(-32'sd1000000000);
		send_value(32'sd123456789);
		send_value(-32'sd987654321);
	endtask

	task automatic test_random(input int count, input int send_pct, input int recv_pct);
		longint lo;
		longint hi;
		longint mag;
		int     ndigits;
		logic signed [VALUE_BITS-1:0] v;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count) begin
			if ($urandom_range(3) == 0) begin
				v = $urandom;
			end else begin
				ndigits = $urandom_range(1, 10);
				lo = 1;
				repeat (ndigits - 1) lo = lo * 10;
				hi = lo * 10 - 1;
				if (ndigits == 1)
					lo = 0;
				if (hi > 64'sd2147483647)
					hi = 64'sd2147483647;
				mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
				v = $urandom_range(1) ? -mag[31:0] : mag[31:0];
			end
			send_value(v);
		end
	endtask

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		text_char_t tc;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_text.size() == 0) begin
				$display("%0t: unexpected character, expected none, actual %h last %b",
					$time, character, last);
				errors++;
			end else begin
				tc = expected_text.pop_front();
				if (character !== tc.code) begin
					$display("%0t: character mismatch, expected %h, actual %h",
						$time, tc.code, character);
					errors++;
				end
				if (last !== tc.is_last) begin
					$display("%0t: last mismatch, expected %b, actual %b",
						$time, tc.is_last, last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
				$display("signed_int_to_decimal_ascii_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		errors         = 0;
		stuck_cycles   = 0;
		send_idle_pct  = 8;
		recv_stall_pct = 72;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		value          = '0;
		out_stall      = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_digit_boundaries();
		test_random(67, 8, 72);
		test_random(67, 72, 8);
		test_random(66, 0, 0);

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_text.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_text.size() != 0) begin
			$display("%0t: %0d expected characters never arrived, next expected %h",
				$time, expected_text.size(), expected_text[0].code);
			errors++;
		end
		if (errors == 0) begin
			$display("signed_int_to_decimal_ascii_tb: PASS");
		end else begin
			$display("signed_int_to_decimal_ascii_tb: FAIL");
		end
		$finish;
	end

endmodule
